[src/tcrp_pkg.sv]
// ----------------------------------------------------------------------------
// tcrp_pkg
// Shared constants, types and helpers of the TTL-aware cache replacement table.
// ----------------------------------------------------------------------------
package tcrp_pkg;

	localparam int ENTRIES = 8;
	localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int TAG_W   = 64;
	localparam int TIME_W  = 32;
	localparam int TTL_W   = 31;
	localparam int EXP_W   = 33;
	localparam int SLOT_W  = 3;
	localparam int ACT_W   = 3;

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_SKIP    = 3'd0,
		ACT_EXPIRED = 3'd1,
		ACT_EMPTY   = 3'd2,
		ACT_OLDEST  = 3'd3,
		ACT_HIT     = 3'd4,
		ACT_MISS    = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// reported slot is the low bits of the index
	function automatic logic [SLOT_W-1:0] slot_of(input idx_t idx);
		logic [IDX_W+SLOT_W-1:0] ext;
		ext = {{SLOT_W{1'b0}}, idx};
		return ext[SLOT_W-1:0];
	endfunction

endpackage

[src/tcrp_req_if.sv]
// ----------------------------------------------------------------------------
// tcrp_req_if
// Request channel: insert or lookup word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tcrp_req_if;
	logic                          valid;
	logic                          ready;
	logic                          command;
	logic [tcrp_pkg::TAG_W-1:0]    name_tag;
	logic [tcrp_pkg::TIME_W-1:0]   now_seconds;
	logic [tcrp_pkg::TTL_W-1:0]    ttl_seconds;
	logic                          has_answers;

	modport source (output valid, command, name_tag, now_seconds, ttl_seconds, has_answers,
		input ready);
	modport sink (input valid, command, name_tag, now_seconds, ttl_seconds, has_answers,
		output ready);
endinterface

[src/tcrp_rsp_if.sv]
// ----------------------------------------------------------------------------
// tcrp_rsp_if
// Response channel: one result word per request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tcrp_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [tcrp_pkg::ACT_W-1:0]    action;
	logic [tcrp_pkg::SLOT_W-1:0]   slot;
	logic [tcrp_pkg::TTL_W-1:0]    remaining_ttl;
	logic [tcrp_pkg::TAG_W-1:0]    evicted_tag;

	modport source (output valid, action, slot, remaining_ttl, evicted_tag, input ready);
	modport sink (input valid, action, slot, remaining_ttl, evicted_tag, output ready);
endinterface

[src/ttl_cache_replacement_policy_top.sv]
// ----------------------------------------------------------------------------
// ttl_cache_replacement_policy_top
// Table of cached name records with expiry; insert and lookup by name tag.
// ----------------------------------------------------------------------------
// A request word is taken only while the block is idle. The table is then
// scanned one entry per cycle through a single compare stage (tag match,
// expiry test, empty test, earliest arrival). After the last entry the
// done state writes the chosen slot and loads the result register, and
// the block goes back to idle, so a new word is taken only once the last
// one has left its done state. The result register lets the next request
// be accepted while a result waits; that request then stalls in its write
// cycle until the waiting word is taken.
// Inserts without answers leave the table untouched and report skipped.
module ttl_cache_replacement_policy_top (
	input  logic       clk,
	input  logic       arst_n,
	tcrp_req_if.sink   req,
	tcrp_rsp_if.source rsp
);
	import tcrp_pkg::*;

	state_t state_q, state_nxt;

	// table
	logic               valid_q [ENTRIES];
	logic [TAG_W-1:0]   tag_q   [ENTRIES];
	logic [TIME_W-1:0]  arr_q   [ENTRIES];
	logic [EXP_W-1:0]   exp_q   [ENTRIES];

	// captured request
	logic               cmd_q, ans_q;
	logic [TAG_W-1:0]   rtag_q;
	logic [TIME_W-1:0]  now_q;
	logic [TTL_W-1:0]   ttl_q;

	// scan state
	idx_t               idx_q;
	logic               hit_q, expf_q, empf_q;
	idx_t               hit_idx_q, exp_idx_q, emp_idx_q, min_idx_q;
	logic [EXP_W-1:0]   hit_exp_q;
	logic [TAG_W-1:0]   exp_tag_q, min_tag_q;
	logic [TIME_W-1:0]  min_arr_q;

	// result register
	logic               rsp_valid_q;
	action_t            act_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [TTL_W-1:0]   rem_q;
	logic [TAG_W-1:0]   evt_q;

	logic               accept, scan_last, load, wr_en;
	logic               rd_valid, rd_expired, rd_hit;
	logic [TAG_W-1:0]   rd_tag;
	logic [TIME_W-1:0]  rd_arr;
	logic [EXP_W-1:0]   rd_exp;
	action_t            act_nxt;
	idx_t               pick;
	logic [SLOT_W-1:0]  slot_nxt;
	logic [TTL_W-1:0]   rem_nxt;
	logic [TAG_W-1:0]   evt_nxt;
	logic [EXP_W-1:0]   rem_full;

	assign accept    = req.valid && req.ready;
	assign scan_last = (idx_q == IDX_W'(ENTRIES - 1));

	// one entry read per cycle at the scan index
	assign rd_valid   = valid_q[idx_q];
	assign rd_tag     = tag_q[idx_q];
	assign rd_arr     = arr_q[idx_q];
	assign rd_exp     = exp_q[idx_q];
	assign rd_expired = rd_valid && ({1'b0, now_q} > rd_exp);
	assign rd_hit     = rd_valid && !rd_expired && (rd_tag == rtag_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		req.ready = 1'b0;
		load      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_nxt = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					load      = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// result selection
	assign rem_full = hit_exp_q - {1'b0, now_q};

	always_comb begin
		act_nxt  = ACT_SKIP;
		pick     = min_idx_q;
		slot_nxt = '0;
		rem_nxt  = '0;
		evt_nxt  = '0;
		if (cmd_q) begin
			if (hit_q) begin
				act_nxt  = ACT_HIT;
				slot_nxt = slot_of(hit_idx_q);
				rem_nxt  = (rem_full[EXP_W-1:TTL_W] != '0) ? {TTL_W{1'b1}} : rem_full[TTL_W-1:0];
			end else begin
				act_nxt = ACT_MISS;
			end
		end else if (ans_q) begin
			if (expf_q) begin
				act_nxt = ACT_EXPIRED;
				pick    = exp_idx_q;
				evt_nxt = exp_tag_q;
			end else if (empf_q) begin
				act_nxt = ACT_EMPTY;
				pick    = emp_idx_q;
			end else begin
				act_nxt = ACT_OLDEST;
				pick    = min_idx_q;
				evt_nxt = min_tag_q;
			end
			slot_nxt = slot_of(pick);
		end
	end

	assign wr_en = load && !cmd_q && ans_q;

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= req.command;
			rtag_q <= req.name_tag;
			now_q  <= req.now_seconds;
			ttl_q  <= req.ttl_seconds;
			ans_q  <= req.has_answers;
		end
	end

	// scan flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			hit_q  <= 1'b0;
			expf_q <= 1'b0;
			empf_q <= 1'b0;
		end else if (accept) begin
			idx_q  <= '0;
			hit_q  <= 1'b0;
			expf_q <= 1'b0;
			empf_q <= 1'b0;
		end else if (state_q == ST_SCAN) begin
			idx_q <= idx_q + IDX_W'(1);
			if (rd_hit) begin
				hit_q <= 1'b1;
			end
			if (rd_expired) begin
				expf_q <= 1'b1;
			end
			if (!rd_valid) begin
				empf_q <= 1'b1;
			end
		end
	end

	// scan payload: first hit, first expired, first empty, earliest arrival
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN) begin
			if (rd_hit && !hit_q) begin
				hit_idx_q <= idx_q;
				hit_exp_q <= rd_exp;
			end
			if (rd_expired && !expf_q) begin
				exp_idx_q <= idx_q;
				exp_tag_q <= rd_tag;
			end
			if (!rd_valid && !empf_q) begin
				emp_idx_q <= idx_q;
			end
			if (idx_q == '0 || rd_arr < min_arr_q) begin
				min_idx_q <= idx_q;
				min_arr_q <= rd_arr;
				min_tag_q <= rd_tag;
			end
		end
	end

	// table write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else if (wr_en) begin
			valid_q[pick] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tag_q[pick] <= rtag_q;
			arr_q[pick] <= now_q;
			exp_q[pick] <= {1'b0, now_q} + {2'b00, ttl_q};
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			act_q  <= act_nxt;
			slot_q <= slot_nxt;
			rem_q  <= rem_nxt;
			evt_q  <= evt_nxt;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.action        = act_q;
	assign rsp.slot          = slot_q;
	assign rsp.remaining_ttl = rem_q;
	assign rsp.evicted_tag   = evt_q;

endmodule

[src/tcrp_checker.sv]
// ----------------------------------------------------------------------------
// tcrp_checker
// Port-level checks on the cache replacement table, bound to the top level.
// ----------------------------------------------------------------------------
module tcrp_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [tcrp_pkg::ACT_W-1:0]    action,
	input logic [tcrp_pkg::SLOT_W-1:0]   slot,
	input logic [tcrp_pkg::TTL_W-1:0]    remaining_ttl,
	input logic [tcrp_pkg::TAG_W-1:0]    evicted_tag
);
	import tcrp_pkg::*;

	// ready drops once a word is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while scan in progress");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && action == ACT_MISS |-> slot == '0 && remaining_ttl == '0
			&& evicted_tag == '0)
		else $error("miss word carries non-zero fields");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && action == ACT_HIT |-> evicted_tag == '0)
		else $error("hit word reports an evicted tag");

	a_insert_no_ttl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (action == ACT_SKIP || action == ACT_EXPIRED || action == ACT_EMPTY
			|| action == ACT_OLDEST) |-> remaining_ttl == '0)
		else $error("insert word reports remaining time");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(action) && $stable(evicted_tag))
		else $error("stalled response word changed");

endmodule

bind ttl_cache_replacement_policy_top tcrp_checker u_tcrp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.action        (rsp.action),
	.slot          (rsp.slot),
	.remaining_ttl (rsp.remaining_ttl),
	.evicted_tag   (rsp.evicted_tag)
);

[verif/ttl_cache_replacement_policy_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttl_cache_replacement_policy_top_tb
// Drives insert and lookup words into the TTL cache table and checks every
// result word against a behavioural copy of the table kept in the bench.
// Directed words cover the corners; random traffic over a small tag pool
// and a slowly moving clock gives hits, expiry reuse and evictions.
// ----------------------------------------------------------------------------
module ttl_cache_replacement_policy_top_tb;
	import tcrp_pkg::*;

	localparam logic CMD_INSERT    = 1'b0;
	localparam logic CMD_LOOKUP    = 1'b1;
	localparam int   IDLE_MAX      = 18;
	localparam int   CYCLE_LIMIT   = 600000;
	localparam int   RANDOM_WORDS  = 1820;
	localparam int   BURST_WORDS   = 12;
	localparam int   HOLD_CYCLES   = 200;
	localparam int   DRAIN_CYCLES  = 4 * (ENTRIES + 2);
	localparam int   MISMATCH_SHOW = 10;
	localparam int   TAG_POOL      = 10;
	localparam logic [TTL_W-1:0] TTL_MAX = {TTL_W{1'b1}};
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	typedef struct packed {
		action_t             action;
		logic [SLOT_W-1:0]   slot;
		logic [TTL_W-1:0]    remaining_ttl;
		logic [TAG_W-1:0]    evicted_tag;
	} table_result_t;

	logic clk;
	logic arst_n;

	tcrp_req_if req ();
	tcrp_rsp_if rsp ();

	ttl_cache_replacement_policy_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// bench copy of the table
	logic              row_valid   [ENTRIES];
	logic [TAG_W-1:0]  row_tag     [ENTRIES];
	logic [TIME_W-1:0] row_arrival [ENTRIES];
	logic [EXP_W-1:0]  row_expiry  [ENTRIES];

	table_result_t pending_results[$];
	int  mismatches  = 0;
	int  cycle_count = 0;
	int  hold_len    = 0;
	logic rx_hold    = 1'b0;
	bit  tx_idle     = 1'b1;
	bit  rx_idle     = 1'b1;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("ttl_cache_replacement_policy_top_tb failed");
		$finish;
	end

	function automatic int idle_cycles(input bit on);
		return on ? int'($urandom_range(0, IDLE_MAX)) : 0;
	endfunction

	// updates the bench table and returns the result word the block should give
	function automatic table_result_t table_result(input logic cmd, input logic [TAG_W-1:0] tag,
			input logic [TIME_W-1:0] now, input logic [TTL_W-1:0] ttl, input logic answers);
		table_result_t r;
		int pick;
		logic [EXP_W-1:0] left;
		r = '0;
		r.action = ACT_SKIP;
		pick = -1;
		if (cmd == CMD_LOOKUP) begin
			r.action = ACT_MISS;
			for (int i = 0; i < ENTRIES; i++)
				if (pick < 0 && row_valid[i] && row_tag[i] == tag && !({1'b0, now} > row_expiry[i]))
					pick = i;
			if (pick >= 0) begin
				left = row_expiry[pick] - {1'b0, now};
				r.action = ACT_HIT;
				r.slot = pick[SLOT_W-1:0];
				r.remaining_ttl = (left > {2'b0, TTL_MAX}) ? TTL_MAX : left[TTL_W-1:0];
			end
			return r;
		end
		if (!answers)
			return r;
		for (int i = 0; i < ENTRIES; i++)
			if (pick < 0 && row_valid[i] && {1'b0, now} > row_expiry[i]) begin
				pick = i;
				r.action = ACT_EXPIRED;
			end
		for (int i = 0; i < ENTRIES; i++)
			if (pick < 0 && !row_valid[i]) begin
				pick = i;
				r.action = ACT_EMPTY;
			end
		if (pick < 0) begin
			// full and nothing stale: earliest arrival, lowest index wins ties
			pick = 0;
			for (int i = 1; i < ENTRIES; i++)
				if (row_arrival[i] < row_arrival[pick])
					pick = i;
			r.action = ACT_OLDEST;
		end
		if (r.action != ACT_EMPTY)
			r.evicted_tag = row_tag[pick];
		r.slot = pick[SLOT_W-1:0];
		row_valid[pick]   = 1'b1;
		row_tag[pick]     = tag;
		row_arrival[pick] = now;
		row_expiry[pick]  = {1'b0, now} + {2'b0, ttl};
		return r;
	endfunction

	task automatic send_word(input logic cmd, input logic [TAG_W-1:0] tag,
			input logic [TIME_W-1:0] now, input logic [TTL_W-1:0] ttl, input logic answers);
		int gap;
		gap = idle_cycles(tx_idle);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid       <= 1'b1;
		req.command     <= cmd;
		req.name_tag    <= tag;
		req.now_seconds <= now;
		req.ttl_seconds <= ttl;
		req.has_answers <= answers;
		do @(posedge clk); while (!req.ready);
		pending_results.push_back(table_result(cmd, tag, now, ttl, answers));
	endtask

	// result side: random stalls, long hold-off on request
	initial begin
		table_result_t want;
		int stall;
		rsp.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = idle_cycles(rx_idle);
			if (stall > 0 || rx_hold) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
				while (rx_hold) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MISMATCH_SHOW)
					$display("unexpected result word: action %0d slot %0d ttl %0d tag %h",
						rsp.action, rsp.slot, rsp.remaining_ttl, rsp.evicted_tag);
			end else begin
				want = pending_results.pop_front();
				if (rsp.action !== want.action || rsp.slot !== want.slot ||
						rsp.remaining_ttl !== want.remaining_ttl ||
						rsp.evicted_tag !== want.evicted_tag) begin
					mismatches++;
					if (mismatches <= MISMATCH_SHOW)
						$display({"mismatch at %0t: exp act %0d slot %0d ttl %0d tag %h,",
							" got act %0d slot %0d ttl %0d tag %h"},
							$realtime, want.action, want.slot, want.remaining_ttl,
							want.evicted_tag, rsp.action, rsp.slot, rsp.remaining_ttl,
							rsp.evicted_tag);
				end
			end
		end
	end

	initial begin
		forever begin
			wait (hold_len != 0);
			rx_hold <= 1'b1;
			repeat (hold_len) @(posedge clk);
			rx_hold <= 1'b0;
			hold_len = 0;
		end
	end

	task automatic test_empty_table();
		send_word(CMD_LOOKUP, '0, '0, '0, 1'b0);
		send_word(CMD_LOOKUP, '1, TIME_MAX, TTL_MAX, 1'b1);
		// insert without answers leaves the table alone
		send_word(CMD_INSERT, '1, TIME_MAX, TTL_MAX, 1'b0);
	endtask

	task automatic test_fill_and_hit();
		logic [TAG_W-1:0] tags [ENTRIES];
		logic [TTL_W-1:0] ttls [ENTRIES];
		tags = '{64'h0, '1, 64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A,
			{$urandom(), $urandom()}, {$urandom(), $urandom()},
			{$urandom(), $urandom()}, {$urandom(), $urandom()}};
		ttls = '{31'd0, 31'd5, TTL_MAX, 31'd1, 31'd100, 31'd100, 31'd100, 31'd100};
		for (int i = 0; i < ENTRIES; i++)
			send_word(CMD_INSERT, tags[i], 32'd1000, ttls[i], 1'b1);
		// zero ttl: still live at its expiry second, gone one later
		send_word(CMD_LOOKUP, tags[0], 32'd1000, '0, 1'b0);
		send_word(CMD_LOOKUP, '1, 32'd1000, '0, 1'b0);
		send_word(CMD_LOOKUP, tags[0], 32'd1001, '0, 1'b0);
	endtask

	task automatic test_replacement();
		send_word(CMD_INSERT, {$urandom(), $urandom()}, 32'd1001, 31'd40, 1'b1);
		send_word(CMD_INSERT, {$urandom(), $urandom()}, 32'd1002, 31'd40, 1'b1);
		send_word(CMD_INSERT, {$urandom(), $urandom()}, 32'd1003, 31'd40, 1'b1);
	endtask

	task automatic test_wide_time();
		logic [TAG_W-1:0] tag;
		tag = {$urandom(), $urandom()};
		// expiry needs the 33rd bit here
		send_word(CMD_INSERT, tag, TIME_MAX, TTL_MAX, 1'b1);
		send_word(CMD_LOOKUP, tag, TIME_MAX, '0, 1'b0);
		// clock behind arrival: remaining time saturates
		send_word(CMD_LOOKUP, tag, 32'd0, '0, 1'b0);
	endtask

	task automatic test_backpressure();
		tx_idle  = 1'b0;
		hold_len = HOLD_CYCLES;
		for (int n = 0; n < BURST_WORDS; n++)
			send_word(logic'($urandom_range(0, 1)), {$urandom(), $urandom()},
				32'd5000 + n, 31'($urandom_range(0, 60)), 1'b1);
	endtask

	task automatic test_random_traffic(input int words);
		logic [TAG_W-1:0]  pool [TAG_POOL];
		logic [TIME_W-1:0] wall;
		logic [TIME_W-1:0] stamp;
		logic [TAG_W-1:0]  tag;
		logic [TTL_W-1:0]  ttl;
		logic              cmd;
		logic              answers;
		int                roll;
		foreach (pool[k])
			pool[k] = {$urandom(), $urandom()};
		wall = $urandom_range(0, 1 << 20);
		for (int n = 0; n < words; n++) begin
			if (n % 64 == 0) begin
				tx_idle = 1'($urandom_range(0, 1));
				rx_idle = 1'($urandom_range(0, 1));
			end
			roll = $urandom_range(0, 99);
			wall = wall + $urandom_range(0, 3);
			if (roll < 2)
				wall = $urandom();
			else if (roll < 4)
				wall = TIME_MAX - $urandom_range(0, 5);
			if ($urandom_range(0, 49) == 0)
				pool[$urandom_range(0, TAG_POOL - 1)] = {$urandom(), $urandom()};
			stamp = ($urandom_range(0, 19) == 0) ? wall - $urandom_range(1, 50) : wall;
			tag = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, TAG_POOL - 1)]
				: {$urandom(), $urandom()};
			roll = $urandom_range(0, 99);
			if (roll < 75)
				ttl = TTL_W'($urandom_range(0, 40));
			else if (roll < 90)
				ttl = TTL_W'($urandom_range(0, 32'h7FFF_FFFF));
			else if (roll < 95)
				ttl = TTL_MAX;
			else
				ttl = '0;
			cmd     = 1'($urandom_range(0, 1));
			answers = ($urandom_range(0, 9) != 0);
			send_word(cmd, tag, stamp, ttl, answers);
		end
	endtask

	initial begin
		foreach (row_valid[i])
			row_valid[i] = 1'b0;
		arst_n          <= 1'b0;
		req.valid       <= 1'b0;
		req.command     <= CMD_INSERT;
		req.name_tag    <= '0;
		req.now_seconds <= '0;
		req.ttl_seconds <= '0;
		req.has_answers <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_fill_and_hit();
		test_replacement();
		test_wide_time();
		test_backpressure();
		test_random_traffic(RANDOM_WORDS);

		req.valid <= 1'b0;
		rx_idle = 1'b0;
		wait (pending_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("ttl_cache_replacement_policy_top_tb passed");
		else
			$display("ttl_cache_replacement_policy_top_tb failed");
		$finish;
	end

endmodule

[files.f]
src/tcrp_pkg.sv
src/tcrp_req_if.sv
src/tcrp_rsp_if.sv
src/ttl_cache_replacement_policy_top.sv
src/tcrp_checker.sv
verif/ttl_cache_replacement_policy_top_tb.sv
